[hdl/fdsu_pkg.sv]
// shared types and constants of the forth dual stack unit
// no dependencies; imported by every module of the block
package fdsu_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int CELL_W      = 64;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = $clog2(STACK_DEPTH);
   localparam int STEP_W      = $clog2(CELL_W);

   typedef enum logic [4:0] {
      KIND_LIT     = 5'd0,
      KIND_PRINT   = 5'd1,
      KIND_DEPTH   = 5'd2,
      KIND_ADD     = 5'd3,
      KIND_SUB     = 5'd4,
      KIND_MUL     = 5'd5,
      KIND_DIV     = 5'd6,
      KIND_DROP    = 5'd7,
      KIND_PICK    = 5'd8,
      KIND_ROLL    = 5'd9,
      KIND_EQ      = 5'd10,
      KIND_NE      = 5'd11,
      KIND_GT      = 5'd12,
      KIND_LT      = 5'd13,
      KIND_TOR     = 5'd14,
      KIND_RFROM   = 5'd15,
      KIND_RFETCH  = 5'd16,
      KIND_EMIT    = 5'd17,
      KIND_QBRANCH = 5'd18,
      KIND_DO      = 5'd19,
      KIND_LOOP    = 5'd20,
      KIND_CLEAR   = 5'd21
   } kind_type;

   typedef enum logic [2:0] {
      STS_OK     = 3'd0,
      STS_UNDER  = 3'd1,
      STS_OVER   = 3'd2,
      STS_ZDIV   = 3'd3,
      STS_BADIDX = 3'd4
   } status_type;

   // what one cell loads in a cycle
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_UP1,
      CELL_UP2,
      CELL_DN1,
      CELL_DN2
   } cell_op_type;

   // what a whole stack does in a cycle
   typedef enum logic [2:0] {
      STK_HOLD,
      STK_PUSH,
      STK_POP,
      STK_PUSH2,
      STK_POP2,
      STK_REPLACE,
      STK_SWAP
   } stack_cmd_type;

   typedef struct packed {
      stack_cmd_type     cmd;
      logic [CELL_W-1:0] new0;
      logic [CELL_W-1:0] new1;
      logic [IDX_W-1:0]  pos;
   } stack_ctl_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_ALU,
      FSM_SWAP_UP,
      FSM_DUP,
      FSM_SWAP_DOWN
   } fsm_type;

endpackage

[hdl/forth_dual_stack_unit.sv]
// forth dual stack unit: top level, control sequencer and response register
// simple primitives finish in the idle state; mul and div run in fdsu_alu (one bit per cycle)
// roll k and pick k walk the chosen cell with neighbor swaps (one neighbor swap per cycle)
// the result appears in the cycle after the transaction finishes, held until taken
// reset (synchronous, active high) empties both stacks; cell contents are not cleared
// depends on fdsu_pkg, fdsu_stack, fdsu_cell and fdsu_alu
module forth_dual_stack_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [4:0]         req_kind,
   input  logic signed [63:0] req_literal_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic               rsp_value_valid,
   output logic signed [63:0] rsp_out_value,
   output logic               rsp_branch_taken
);
   import fdsu_pkg::*;

   // sequencer state
   fsm_type          state_ff, state_in;
   logic [CNT_W-1:0] dcount_ff, dcount_in;
   logic [CNT_W-1:0] rcount_ff, rcount_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] klim_ff, klim_in;
   logic             is_pick_ff, is_pick_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic              rsp_vv_ff, rsp_vv_in;
   logic [CELL_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_taken_ff, rsp_taken_in;
   logic              rsp_load;

   stack_ctl_type     dctl, rctl;
   logic [CELL_W-1:0] dtop0, dtop1, rtop0, rtop1;

   logic              alu_start, alu_is_div, alu_done;
   logic [CELL_W-1:0] alu_result;

   logic              accept;
   logic [CNT_W-1:0]  rest;
   logic              k_too_big;

   // a new transaction waits for the sequencer and a free response slot
   assign req_stall = (state_ff != FSM_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign rest      = dcount_ff - 1'b1;
   assign k_too_big = (dtop0[CELL_W-1:CNT_W] != '0) || (dtop0[CNT_W-1:0] > rest);

   always_comb begin
      state_in      = state_ff;
      dcount_in     = dcount_ff;
      rcount_in     = rcount_ff;
      pos_in        = pos_ff;
      klim_in       = klim_ff;
      is_pick_in    = is_pick_ff;
      dctl          = '{cmd: STK_HOLD, new0: '0, new1: '0, pos: pos_ff};
      rctl          = '{cmd: STK_HOLD, new0: '0, new1: '0, pos: '0};
      alu_start     = 1'b0;
      alu_is_div    = 1'b0;
      rsp_load      = 1'b0;
      rsp_status_in = STS_OK;
      rsp_vv_in     = 1'b0;
      rsp_value_in  = '0;
      rsp_taken_in  = 1'b0;

      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               rsp_load = 1'b1;
               case (kind_type'(req_kind))
                  KIND_LIT, KIND_DEPTH: begin
                     if (dcount_ff >= CNT_W'(STACK_DEPTH)) begin
                        rsp_status_in = STS_OVER;
                     end else begin
                        dctl.cmd  = STK_PUSH;
                        dctl.new0 = (kind_type'(req_kind) == KIND_LIT) ?
                                    req_literal_value : CELL_W'(dcount_ff);
                        dcount_in = dcount_ff + 1'b1;
                     end
                  end
                  KIND_PRINT, KIND_DROP, KIND_EMIT, KIND_QBRANCH: begin
                     if (dcount_ff == '0) begin
                        rsp_status_in = STS_UNDER;
                     end else begin
                        dctl.cmd  = STK_POP;
                        dcount_in = dcount_ff - 1'b1;
                        case (kind_type'(req_kind))
                           KIND_PRINT: begin
                              rsp_vv_in    = 1'b1;
                              rsp_value_in = dtop0;
                           end
                           KIND_EMIT: begin
                              rsp_vv_in    = 1'b1;
                              rsp_value_in = {{(CELL_W - 8){1'b0}}, dtop0[7:0]};
                           end
                           KIND_QBRANCH: rsp_taken_in = (dtop0 == '0);
                           default: ;
                        endcase
                     end
                  end
                  KIND_ADD, KIND_SUB, KIND_EQ, KIND_NE, KIND_GT, KIND_LT: begin
                     if (dcount_ff < CNT_W'(2)) begin
                        rsp_status_in = STS_UNDER;
                     end else begin
                        dctl.cmd  = STK_REPLACE;
                        dcount_in = dcount_ff - 1'b1;
                        case (kind_type'(req_kind))
                           KIND_ADD: dctl.new0 = dtop1 + dtop0;
                           KIND_SUB: dctl.new0 = dtop1 - dtop0;
                           KIND_EQ:  dctl.new0 = {CELL_W{dtop1 == dtop0}};
                           KIND_NE:  dctl.new0 = {CELL_W{dtop1 != dtop0}};
                           KIND_GT:  dctl.new0 = {CELL_W{$signed(dtop1) > $signed(dtop0)}};
                           default:  dctl.new0 = {CELL_W{$signed(dtop1) < $signed(dtop0)}};
                        endcase
                     end
                  end
                  KIND_MUL, KIND_DIV: begin
                     if (dcount_ff < CNT_W'(2)) begin
                        rsp_status_in = STS_UNDER;
                     end else if (kind_type'(req_kind) == KIND_DIV && dtop0 == '0) begin
                        rsp_status_in = STS_ZDIV;
                     end else begin
                        // result replaces the top pair when the unit is done
                        rsp_load   = 1'b0;
                        alu_start  = 1'b1;
                        alu_is_div = (kind_type'(req_kind) == KIND_DIV);
                        dcount_in  = dcount_ff - 1'b1;
                        state_in   = FSM_ALU;
                     end
                  end
                  KIND_PICK, KIND_ROLL: begin
                     if (dcount_ff == '0) begin
                        rsp_status_in = STS_UNDER;
                     end else if ($signed(dtop0) < $signed(CELL_W'(1))) begin
                        rsp_status_in = STS_BADIDX;
                     end else if (k_too_big) begin
                        rsp_status_in = STS_UNDER;
                     end else begin
                        // drop k, then walk the chosen cell with neighbor swaps
                        dctl.cmd   = STK_POP;
                        is_pick_in = (kind_type'(req_kind) == KIND_PICK);
                        klim_in    = IDX_W'(dtop0[CNT_W-1:0] - 1'b1);
                        pos_in     = IDX_W'(dtop0[CNT_W-1:0] - CNT_W'(2));
                        dcount_in  = (kind_type'(req_kind) == KIND_PICK) ? dcount_ff : rest;
                        if (dtop0[CNT_W-1:0] > CNT_W'(1)) begin
                           rsp_load = 1'b0;
                           state_in = FSM_SWAP_UP;
                        end else if (kind_type'(req_kind) == KIND_PICK) begin
                           rsp_load = 1'b0;
                           state_in = FSM_DUP;
                        end
                     end
                  end
                  KIND_TOR: begin
                     if (dcount_ff == '0) begin
                        rsp_status_in = STS_UNDER;
                     end else if (rcount_ff >= CNT_W'(STACK_DEPTH)) begin
                        rsp_status_in = STS_OVER;
                     end else begin
                        dctl.cmd  = STK_POP;
                        rctl.cmd  = STK_PUSH;
                        rctl.new0 = dtop0;
                        dcount_in = dcount_ff - 1'b1;
                        rcount_in = rcount_ff + 1'b1;
                     end
                  end
                  KIND_RFROM, KIND_RFETCH: begin
                     if (rcount_ff == '0) begin
                        rsp_status_in = STS_UNDER;
                     end else if (dcount_ff >= CNT_W'(STACK_DEPTH)) begin
                        rsp_status_in = STS_OVER;
                     end else begin
                        dctl.cmd  = STK_PUSH;
                        dctl.new0 = rtop0;
                        dcount_in = dcount_ff + 1'b1;
                        if (kind_type'(req_kind) == KIND_RFROM) begin
                           rctl.cmd  = STK_POP;
                           rcount_in = rcount_ff - 1'b1;
                        end
                     end
                  end
                  KIND_DO: begin
                     if (dcount_ff < CNT_W'(2)) begin
                        rsp_status_in = STS_UNDER;
                     end else if ($signed(dtop1) <= $signed(dtop0)) begin
                        // loop skipped
                        rsp_taken_in = 1'b1;
                        dctl.cmd     = STK_POP2;
                        dcount_in    = dcount_ff - CNT_W'(2);
                     end else if (rcount_ff > CNT_W'(STACK_DEPTH - 2)) begin
                        rsp_status_in = STS_OVER;
                     end else begin
                        dctl.cmd  = STK_POP2;
                        dcount_in = dcount_ff - CNT_W'(2);
                        rctl.cmd  = STK_PUSH2;
                        rctl.new0 = dtop1;
                        rctl.new1 = dtop0 + 1'b1;
                        rcount_in = rcount_ff + CNT_W'(2);
                     end
                  end
                  KIND_LOOP: begin
                     if (rcount_ff < CNT_W'(2)) begin
                        rsp_status_in = STS_UNDER;
                     end else if (dcount_ff > CNT_W'(STACK_DEPTH - 2)) begin
                        rsp_status_in = STS_OVER;
                     end else begin
                        dctl.cmd  = STK_PUSH2;
                        dctl.new0 = rtop1;
                        dctl.new1 = rtop0;
                        dcount_in = dcount_ff + CNT_W'(2);
                        rctl.cmd  = STK_POP2;
                        rcount_in = rcount_ff - CNT_W'(2);
                     end
                  end
                  KIND_CLEAR: begin
                     dcount_in = '0;
                     rcount_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         FSM_ALU: begin
            if (alu_done) begin
               dctl.cmd  = STK_REPLACE;
               dctl.new0 = alu_result;
               rsp_load  = 1'b1;
               state_in  = FSM_IDLE;
            end
         end
         FSM_SWAP_UP: begin
            // bubble the chosen cell toward the top
            dctl.cmd = STK_SWAP;
            pos_in   = pos_ff - 1'b1;
            if (pos_ff == '0) begin
               if (is_pick_ff) begin
                  state_in = FSM_DUP;
               end else begin
                  rsp_load = 1'b1;
                  state_in = FSM_IDLE;
               end
            end
         end
         FSM_DUP: begin
            dctl.cmd  = STK_PUSH;
            dctl.new0 = dtop0;
            pos_in    = IDX_W'(1);
            if (klim_ff == '0) begin
               rsp_load = 1'b1;
               state_in = FSM_IDLE;
            end else begin
               state_in = FSM_SWAP_DOWN;
            end
         end
         FSM_SWAP_DOWN: begin
            // sink the second copy back to where it came from
            dctl.cmd = STK_SWAP;
            pos_in   = pos_ff + 1'b1;
            if (pos_ff == klim_ff) begin
               rsp_load = 1'b1;
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         dcount_ff    <= '0;
         rcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dcount_ff    <= dcount_in;
         rcount_ff    <= rcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff     <= pos_in;
      klim_ff    <= klim_in;
      is_pick_ff <= is_pick_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_vv_ff     <= rsp_vv_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_taken_ff  <= rsp_taken_in;
      end
   end

   // data and return stacks
   fdsu_stack u_data_stack (
      .clock (clock),
      .ctl   (dctl),
      .top0  (dtop0),
      .top1  (dtop1)
   );

   fdsu_stack u_return_stack (
      .clock (clock),
      .ctl   (rctl),
      .top0  (rtop0),
      .top1  (rtop1)
   );

   // shared multiply and divide
   fdsu_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .start  (alu_start),
      .is_div (alu_is_div),
      .opa    (dtop1),
      .opb    (dtop0),
      .done   (alu_done),
      .result (alu_result)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_value_valid  = rsp_vv_ff;
   assign rsp_out_value    = rsp_value_ff;
   assign rsp_branch_taken = rsp_taken_ff;

endmodule

[hdl/fdsu_cell.sv]
// one stack cell: holds a cell value and loads it from a neighbor
// depends on fdsu_pkg
module fdsu_cell (
   input  logic                       clock,
   input  fdsu_pkg::cell_op_type      op,
   input  logic [fdsu_pkg::CELL_W-1:0] up1,
   input  logic [fdsu_pkg::CELL_W-1:0] up2,
   input  logic [fdsu_pkg::CELL_W-1:0] dn1,
   input  logic [fdsu_pkg::CELL_W-1:0] dn2,
   output logic [fdsu_pkg::CELL_W-1:0] value
);
   import fdsu_pkg::*;

   logic [CELL_W-1:0] value_ff;
   logic [CELL_W-1:0] value_in;

   always_comb begin
      case (op)
         CELL_UP1: value_in = up1;
         CELL_UP2: value_in = up2;
         CELL_DN1: value_in = dn1;
         CELL_DN2: value_in = dn2;
         default:  value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

[hdl/fdsu_stack.sv]
// one stack as a row of cells, top of stack in cell 0
// depends on fdsu_pkg and fdsu_cell
module fdsu_stack (
   input  logic                        clock,
   input  fdsu_pkg::stack_ctl_type     ctl,
   output logic [fdsu_pkg::CELL_W-1:0] top0,
   output logic [fdsu_pkg::CELL_W-1:0] top1
);
   import fdsu_pkg::*;

   logic [CELL_W-1:0] cell_value [STACK_DEPTH];

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      localparam logic [IDX_W:0] CELL_IDX = (IDX_W + 1)'(i);
      cell_op_type       op;
      logic [CELL_W-1:0] up1, up2, dn1, dn2;
      logic [IDX_W:0]    pos_lo, pos_hi;

      assign pos_lo = {1'b0, ctl.pos};
      assign pos_hi = pos_lo + 1'b1;

      always_comb begin
         case (ctl.cmd)
            STK_PUSH:    op = CELL_UP1;
            STK_POP:     op = CELL_DN1;
            STK_PUSH2:   op = CELL_UP2;
            STK_POP2:    op = CELL_DN2;
            STK_REPLACE: op = (i == 0) ? CELL_UP1 : CELL_DN1;
            STK_SWAP: begin
               if (pos_lo == CELL_IDX) op = CELL_DN1;
               else if (pos_hi == CELL_IDX) op = CELL_UP1;
               else op = CELL_HOLD;
            end
            default:     op = CELL_HOLD;
         endcase
      end

      if (i == 0) begin : g_top
         assign up1 = ctl.new0;
         assign up2 = ctl.new0;
      end else if (i == 1) begin : g_second
         assign up1 = cell_value[0];
         assign up2 = ctl.new1;
      end else begin : g_inner
         assign up1 = cell_value[i-1];
         assign up2 = cell_value[i-2];
      end

      if (i + 1 < STACK_DEPTH) begin : g_dn1
         assign dn1 = cell_value[i+1];
      end else begin : g_dn1_end
         assign dn1 = '0;
      end

      if (i + 2 < STACK_DEPTH) begin : g_dn2
         assign dn2 = cell_value[i+2];
      end else begin : g_dn2_end
         assign dn2 = '0;
      end

      fdsu_cell u_cell (
         .clock (clock),
         .op    (op),
         .up1   (up1),
         .up2   (up2),
         .dn1   (dn1),
         .dn2   (dn2),
         .value (cell_value[i])
      );
   end

   assign top0 = cell_value[0];
   assign top1 = cell_value[1];

endmodule

[hdl/fdsu_alu.sv]
// iterative multiply and signed divide, one bit per cycle
// depends on fdsu_pkg
module fdsu_alu (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        is_div,
   input  logic [fdsu_pkg::CELL_W-1:0] opa,
   input  logic [fdsu_pkg::CELL_W-1:0] opb,
   output logic                        done,
   output logic [fdsu_pkg::CELL_W-1:0] result
);
   import fdsu_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              is_div_ff, is_div_in;
   logic              neg_ff, neg_in;
   logic [CELL_W-1:0] acc_ff, acc_in;
   logic [CELL_W-1:0] quo_ff, quo_in;
   logic [CELL_W-1:0] opd_ff, opd_in;
   logic [CELL_W:0]   trial;

   assign trial = {acc_ff, quo_ff[CELL_W-1]} - {1'b0, opd_ff};

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      is_div_in = is_div_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      quo_in    = quo_ff;
      opd_in    = opd_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = STEP_W'(CELL_W - 1);
         is_div_in = is_div;
         acc_in    = '0;
         if (is_div) begin
            neg_in = opa[CELL_W-1] ^ opb[CELL_W-1];
            quo_in = opa[CELL_W-1] ? ('0 - opa) : opa;
            opd_in = opb[CELL_W-1] ? ('0 - opb) : opb;
         end else begin
            neg_in = 1'b0;
            quo_in = opb;
            opd_in = opa;
         end
      end else if (busy_ff) begin
         if (is_div_ff) begin
            if (!trial[CELL_W]) begin
               acc_in = trial[CELL_W-1:0];
               quo_in = {quo_ff[CELL_W-2:0], 1'b1};
            end else begin
               acc_in = {acc_ff[CELL_W-2:0], quo_ff[CELL_W-1]};
               quo_in = {quo_ff[CELL_W-2:0], 1'b0};
            end
         end else begin
            if (quo_ff[0]) acc_in = acc_ff + opd_ff;
            opd_in = {opd_ff[CELL_W-2:0], 1'b0};
            quo_in = {1'b0, quo_ff[CELL_W-1:1]};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      is_div_ff <= is_div_in;
      neg_ff    <= neg_in;
      acc_ff    <= acc_in;
      quo_ff    <= quo_in;
      opd_ff    <= opd_in;
   end

   assign done   = done_ff;
   assign result = is_div_ff ? (neg_ff ? ('0 - quo_ff) : quo_ff) : acc_ff;

endmodule

[hdl/fdsu_checker.sv]
// port level checks of the forth dual stack unit, bound to the top level
// depends on fdsu_pkg and forth_dual_stack_unit
module fdsu_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [2:0]         rsp_status,
   input logic               rsp_value_valid,
   input logic signed [63:0] rsp_out_value,
   input logic               rsp_branch_taken
);
   import fdsu_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_out_value))
      else $error("response changed while stalled");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STS_OK |-> !rsp_value_valid && !rsp_branch_taken)
      else $error("error response carries a value or branch");

   a_stall_on_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("transaction accepted with a blocked response");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response after reset");

endmodule

bind forth_dual_stack_unit fdsu_checker u_fdsu_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_value_valid  (rsp_value_valid),
   .rsp_out_value    (rsp_out_value),
   .rsp_branch_taken (rsp_branch_taken)
);
